/* rtl/core/gregorian_date_day_count_convert_assert.svh */
// assertion macros for the date and day count converter
`ifndef GREGORIAN_DATE_DAY_COUNT_CONVERT_ASSERT_SVH
`define GREGORIAN_DATE_DAY_COUNT_CONVERT_ASSERT_SVH

`ifndef SYNTHESIS
`define GDCC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same cycle check failed");
`define GDCC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next cycle check failed");
`else
`define GDCC_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define GDCC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* rtl/core/gdcc_pkg.sv */
// types, unit constants and calendar tables for the date and day count converter
`timescale 1ns / 1ps

package gdcc_pkg;

    typedef struct packed {
        logic        mode;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
        logic [21:0] in_day_count;
    } t_in_item;

    typedef struct packed {
        logic [21:0] out_day_count;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        bad_input;
    } t_out_item;

    typedef logic [22:0] t_opnd;

    localparam logic [3:0] LAST_STEP   = 4'd14;
    localparam logic [3:0] MONTH_LAST  = 4'd11;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;

    localparam t_opnd DAY_UNIT [4] = '{23'd146097, 23'd36524, 23'd1461, 23'd365};
    localparam t_opnd YEAR_UNIT [4] = '{23'd400, 23'd100, 23'd4, 23'd1};

    // unit of one shift-subtract or shift-add step: stages of 6, 2, 5 and 2 bits
    function automatic t_opnd step_const(input logic day_set, input logic [3:0] step);
        logic [1:0] stg;
        logic [2:0] sh;
        t_opnd      base;
        case (step)
            4'd0:    begin stg = 2'd0; sh = 3'd5; end
            4'd1:    begin stg = 2'd0; sh = 3'd4; end
            4'd2:    begin stg = 2'd0; sh = 3'd3; end
            4'd3:    begin stg = 2'd0; sh = 3'd2; end
            4'd4:    begin stg = 2'd0; sh = 3'd1; end
            4'd5:    begin stg = 2'd0; sh = 3'd0; end
            4'd6:    begin stg = 2'd1; sh = 3'd1; end
            4'd7:    begin stg = 2'd1; sh = 3'd0; end
            4'd8:    begin stg = 2'd2; sh = 3'd4; end
            4'd9:    begin stg = 2'd2; sh = 3'd3; end
            4'd10:   begin stg = 2'd2; sh = 3'd2; end
            4'd11:   begin stg = 2'd2; sh = 3'd1; end
            4'd12:   begin stg = 2'd2; sh = 3'd0; end
            4'd13:   begin stg = 2'd3; sh = 3'd1; end
            4'd14:   begin stg = 2'd3; sh = 3'd0; end
            default: begin stg = 2'd3; sh = 3'd0; end
        endcase
        base = day_set ? DAY_UNIT[stg] : YEAR_UNIT[stg];
        return base << sh;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] idx);
        logic [8:0] dbm;
        case (idx)
            4'd0:    dbm = 9'd0;
            4'd1:    dbm = 9'd31;
            4'd2:    dbm = 9'd59;
            4'd3:    dbm = 9'd90;
            4'd4:    dbm = 9'd120;
            4'd5:    dbm = 9'd151;
            4'd6:    dbm = 9'd181;
            4'd7:    dbm = 9'd212;
            4'd8:    dbm = 9'd243;
            4'd9:    dbm = 9'd273;
            4'd10:   dbm = 9'd304;
            4'd11:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

/* rtl/core/gregorian_date_day_count_convert.sv */
// date to day count and day count to date converter on one shared add/subtract unit
//
//   channel  signals                              direction
//   input    i_in_valid  i_in_item   o_in_stall   date or day count in
//   output   o_out_valid o_out_item  i_out_stall  day count, date and flag out
//
// a date skips the shift-add steps when its day is past the end of the month
// an input rejected on its fields alone skips all steps; each waits out any output stall
// the shared unit runs 15 shift-subtract steps, up to 12 month steps, 15 shift-add steps
// one item at a time: o_in_stall is high from acceptance until the result is registered
// a new item is taken while the previous result still waits in the output register
// synchronous active low reset clears the sequencer and the output valid
`timescale 1ns / 1ps

`include "gregorian_date_day_count_convert_assert.svh"

module gregorian_date_day_count_convert #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  gdcc_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output gdcc_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    import gdcc_pkg::*;

    localparam int unsigned LIM_DAYS = YEAR_LIMIT * 365 + YEAR_LIMIT / 4
                                       - YEAR_LIMIT / 100 + YEAR_LIMIT / 400;
    localparam logic [24:0] CNT_LAST = 25'(LIM_DAYS);
    localparam logic [16:0] YEAR_MAX = 17'(YEAR_LIMIT);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_MON  = 3'd3;
    localparam logic [2:0] ST_MAC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [22:0] r_acc, n_acc;
    logic [14:0] r_quo, n_quo;
    logic [3:0]  r_mon, n_mon;
    logic        r_mode, n_mode;
    logic [4:0]  r_day, n_day;
    logic [3:0]  r_month, n_month;
    logic [13:0] r_year, n_year;
    logic [21:0] r_cnt, n_cnt;
    logic        r_bad, n_bad;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    t_opnd       alu_b;
    logic        alu_sub;
    logic [23:0] alu_res;
    logic        alu_neg;

    logic        date_bad;
    logic        cnt_bad;
    logic        leap;
    logic [4:0]  chk_len;
    logic        late_month;

    // shared add/subtract unit
    assign alu_res = {1'b0, r_acc} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                     + {23'd0, alu_sub};
    assign alu_neg = alu_res[23];

    always_comb begin
        case (r_state)
            ST_DIV: begin
                alu_b   = step_const(r_mode, r_step);
                alu_sub = 1'b1;
            end
            ST_MON: begin
                alu_b   = {18'd0, month_days(r_mon, leap)};
                alu_sub = 1'b1;
            end
            ST_MAC: begin
                alu_b   = step_const(!r_mode, r_step);
                alu_sub = 1'b0;
            end
            default: begin
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign date_bad = (i_in_item.in_year == 14'd0)
                   || ({3'd0, i_in_item.in_year} > YEAR_MAX)
                   || (i_in_item.in_month == 4'd0)
                   || (i_in_item.in_month > MONTH_MAX)
                   || (i_in_item.in_day == 5'd0);
    assign cnt_bad  = (i_in_item.in_day_count == 22'd0)
                   || ({3'd0, i_in_item.in_day_count} > CNT_LAST);

    // year decomposed as 400*q0 + 100*q1 + 4*q2 + q3 + 1
    assign leap       = (r_quo[1:0] == 2'd3)
                     && ((r_quo[6:2] != 5'd24) || (r_quo[8:7] == 2'd3));
    assign chk_len    = month_days(r_month - 4'd1, leap);
    assign late_month = (r_month > MONTH_FEB) && leap;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_mon       = r_mon;
        n_mode      = r_mode;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_cnt       = r_cnt;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_in_item.mode;
                    n_day   = i_in_item.in_day;
                    n_month = i_in_item.in_month;
                    n_year  = i_in_item.in_year;
                    n_cnt   = i_in_item.in_day_count;
                    n_step  = 4'd0;
                    n_quo   = '0;
                    if (!i_in_item.mode) begin
                        n_acc   = {9'd0, i_in_item.in_year - 14'd1};
                        n_bad   = date_bad;
                        n_state = date_bad ? ST_FIN : ST_DIV;
                    end else begin
                        n_acc   = {1'b0, i_in_item.in_day_count - 22'd1};
                        n_bad   = cnt_bad;
                        n_state = cnt_bad ? ST_FIN : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_quo  = {r_quo[13:0], !alu_neg};
                if (!alu_neg) begin
                    n_acc = alu_res[22:0];
                end
                n_step = r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    n_step  = 4'd0;
                    n_mon   = 4'd0;
                    n_state = r_mode ? ST_MON : ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_day > chk_len) begin
                    n_bad   = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_acc   = 23'(days_before(r_month - 4'd1)) + 23'(r_day)
                              + 23'(late_month);
                    n_state = ST_MAC;
                end
            end
            ST_MON: begin
                if (!alu_neg && (r_mon != MONTH_LAST)) begin
                    n_acc = alu_res[22:0];
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_day   = r_acc[4:0] + 5'd1;
                    n_month = r_mon + 4'd1;
                    n_acc   = 23'd1;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_quo[14]) begin
                    n_acc = alu_res[22:0];
                end
                n_quo  = {r_quo[13:0], 1'b0};
                n_step = r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    n_step  = 4'd0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_bad) begin
                        n_out_item.out_day_count = 22'd1;
                        n_out_item.out_day       = 5'd1;
                        n_out_item.out_month     = 4'd1;
                        n_out_item.out_year      = 14'd1;
                    end else if (r_mode) begin
                        n_out_item.out_day_count = r_cnt;
                        n_out_item.out_day       = r_day;
                        n_out_item.out_month     = r_month;
                        n_out_item.out_year      = r_acc[13:0];
                    end else begin
                        n_out_item.out_day_count = r_acc[21:0];
                        n_out_item.out_day       = r_day;
                        n_out_item.out_month     = r_month;
                        n_out_item.out_year      = r_year;
                    end
                    n_out_item.bad_input = r_bad;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_quo      <= n_quo;
        r_mon      <= n_mon;
        r_mode     <= n_mode;
        r_day      <= n_day;
        r_month    <= n_month;
        r_year     <= n_year;
        r_cnt      <= n_cnt;
        r_bad      <= n_bad;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `GDCC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `GDCC_ASSERT_IMPL(a_bad_is_first_day, i_clk, i_rst_n, o_out_valid && o_out_item.bad_input,
        o_out_item.out_day_count == 22'd1 && o_out_item.out_day == 5'd1
        && o_out_item.out_month == 4'd1 && o_out_item.out_year == 14'd1)
    `GDCC_ASSERT_IMPL(a_month_range, i_clk, i_rst_n, o_out_valid,
        o_out_item.out_month != 4'd0 && o_out_item.out_month <= MONTH_MAX
        && o_out_item.out_day != 5'd0)
    `GDCC_ASSERT_IMPL(a_month_search, i_clk, i_rst_n, r_state == ST_MON,
        r_mon <= MONTH_LAST && r_acc < 23'd366)

endmodule

/* verif/testbench.sv */
// self-checking testbench for the gregorian date and day count converter
`timescale 1ns / 1ps

module testbench;
    import gdcc_pkg::*;

    localparam int unsigned YEAR_LIMIT = 9999;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned MAX_PRINTED = 40;

    localparam logic MODE_DATE_TO_COUNT = 1'b0;
    localparam logic MODE_COUNT_TO_DATE = 1'b1;

    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURST,
        STALL_TOGGLE
    } t_stall_style;

    class date_count_board;
        t_out_item   pending[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        // days in all years before year y
        static function int unsigned year_start(int unsigned y);
            int unsigned p;
            p = y - 1;
            return p * 365 + p / 4 - p / 100 + p / 400;
        endfunction

        static function int unsigned month_length(int unsigned m, int unsigned y);
            return MONTH_LEN[m - 1] + ((m == MONTH_FEB && leap_year(y)) ? 1 : 0);
        endfunction

        static function int unsigned last_count();
            return year_start(YEAR_LIMIT + 1);
        endfunction

        static function t_out_item convert(t_in_item it);
            t_out_item   r;
            int unsigned d, m, y, cnt, rem, q400, q100, q4, q1;
            bit          bad;
            d = it.in_day;
            m = it.in_month;
            y = it.in_year;
            cnt = it.in_day_count;
            bad = 1'b0;
            if (it.mode == MODE_DATE_TO_COUNT) begin
                if (y < 1 || y > YEAR_LIMIT || m < 1 || m > MONTH_MAX || d < 1 ||
                    d > month_length(m, y)) begin
                    d = 1;
                    m = 1;
                    y = 1;
                    bad = 1'b1;
                end
                cnt = year_start(y) + MONTH_START[m - 1] + d;
                if (m > MONTH_FEB && leap_year(y))
                    cnt++;
            end else begin
                if (cnt == 0 || cnt > last_count()) begin
                    cnt = 1;
                    bad = 1'b1;
                end
                rem = cnt - 1;
                q400 = rem / 146097;
                rem = rem % 146097;
                q100 = rem / 36524;
                if (q100 > 3)
                    q100 = 3;
                rem = rem - q100 * 36524;
                q4 = rem / 1461;
                rem = rem % 1461;
                q1 = rem / 365;
                if (q1 > 3)
                    q1 = 3;
                rem = rem - q1 * 365;
                y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
                m = 1;
                while (m < MONTH_MAX && rem >= month_length(m, y)) begin
                    rem = rem - month_length(m, y);
                    m++;
                end
                d = rem + 1;
            end
            r.out_day_count = 22'(cnt);
            r.out_day = 5'(d);
            r.out_month = 4'(m);
            r.out_year = 14'(y);
            r.bad_input = bad;
            return r;
        endfunction

        function void note_input(t_in_item it);
            pending.push_back(convert(it));
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.out_day_count !== want.out_day_count)
                report($sformatf("out_day_count got %0d want %0d",
                                 got.out_day_count, want.out_day_count));
            if (got.out_day !== want.out_day)
                report($sformatf("out_day got %0d want %0d", got.out_day, want.out_day));
            if (got.out_month !== want.out_month)
                report($sformatf("out_month got %0d want %0d", got.out_month, want.out_month));
            if (got.out_year !== want.out_year)
                report($sformatf("out_year got %0d want %0d", got.out_year, want.out_year));
            if (got.bad_input !== want.bad_input)
                report($sformatf("bad_input got %0b want %0b", got.bad_input, want.bad_input));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_item = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall = 1'b0;

    date_count_board board;
    int unsigned     cycle_count = 0;
    t_stall_style    stall_style = STALL_NONE;
    int unsigned     style_left = 0;
    int unsigned     stall_hold = 0;

    gregorian_date_day_count_convert #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item(i_in_item),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item(o_out_item),
        .i_out_stall(i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // item and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.note_input(i_in_item);
            if (o_out_valid && !i_out_stall)
                board.check_result(o_out_item);
        end
    end

    // output stall pattern, switching style now and then
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            style_left <= $urandom_range(32, 256);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
            end
            STALL_BURST: begin
                if (stall_hold != 0) begin
                    stall_hold <= stall_hold - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        stall_hold <= $urandom_range(1, 40);
                end
            end
            default: begin
                i_out_stall <= ~i_out_stall;
            end
        endcase
    end

    function automatic t_in_item make_item(logic mode, int unsigned d, int unsigned m,
                                           int unsigned y, int unsigned cnt);
        t_in_item it;
        it.mode = mode;
        it.in_day = 5'(d);
        it.in_month = 4'(m);
        it.in_year = 14'(y);
        it.in_day_count = 22'(cnt);
        return it;
    endfunction

    function automatic t_in_item date_item(int unsigned d, int unsigned m, int unsigned y);
        return make_item(MODE_DATE_TO_COUNT, d, m, y, $urandom_range(0, 4194303));
    endfunction

    function automatic t_in_item count_item(int unsigned cnt);
        return make_item(MODE_COUNT_TO_DATE, $urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 16383), cnt);
    endfunction

    function automatic int unsigned pick_year();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 13)
            return $urandom_range(1, YEAR_LIMIT);
        else if (sel < 16)
            return $urandom_range(1, YEAR_LIMIT / 100) * 100;
        else if (sel < 18)
            return $urandom_range(YEAR_LIMIT - 12, YEAR_LIMIT);
        else
            return $urandom_range(1, 12);
    endfunction

    function automatic t_in_item random_item();
        int unsigned sel, y, m, d, cnt;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            y = pick_year();
            m = $urandom_range(1, 12);
            d = ($urandom_range(0, 3) == 0)
                ? date_count_board::month_length(m, y)
                : $urandom_range(1, date_count_board::month_length(m, y));
            return date_item(d, m, y);
        end else if (sel < 60) begin
            return count_item($urandom_range(1, date_count_board::last_count()));
        end else if (sel < 80) begin
            // around a year boundary, including day 366
            y = pick_year();
            cnt = date_count_board::year_start(y) + $urandom_range(1, 366);
            if ($urandom_range(0, 1) == 0)
                cnt = date_count_board::year_start(y) + 365 + $urandom_range(0, 1);
            return count_item(cnt);
        end else if (sel < 86) begin
            // end of february, valid or not
            y = pick_year();
            return date_item($urandom_range(28, 31), MONTH_FEB, y);
        end else begin
            return make_item(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 16383),
                             $urandom_range(0, 4194303));
        end
    endfunction

    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        t_in_item    directed[$];
        int unsigned sent, burst, gap;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(date_item(1, 1, 1));
        directed.push_back(date_item(31, 12, YEAR_LIMIT));
        directed.push_back(date_item(29, 2, 2000));
        directed.push_back(date_item(29, 2, 1900));
        directed.push_back(date_item(28, 2, 1900));
        directed.push_back(date_item(29, 2, 2024));
        directed.push_back(date_item(1, 3, 2000));
        directed.push_back(date_item(0, 5, 1234));
        directed.push_back(date_item(10, 0, 1234));
        directed.push_back(date_item(10, 13, 1234));
        directed.push_back(date_item(31, 15, 16383));
        directed.push_back(date_item(15, 6, 0));
        directed.push_back(date_item(15, 6, YEAR_LIMIT + 1));
        directed.push_back(date_item(31, 4, 2021));
        directed.push_back(date_item(31, 12, 4));
        directed.push_back(count_item(0));
        directed.push_back(count_item(1));
        directed.push_back(count_item(date_count_board::last_count()));
        directed.push_back(count_item(date_count_board::last_count() + 1));
        directed.push_back(count_item(4194303));
        directed.push_back(count_item(366));
        directed.push_back(count_item(1461));
        directed.push_back(count_item(1155));
        directed.push_back(count_item(36524));
        directed.push_back(count_item(146097));
        foreach (directed[i])
            send_item(directed[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            while (burst != 0 && sent < RANDOM_ITEMS) begin
                send_item(random_item());
                sent++;
                burst--;
            end
            if (sent >= RANDOM_ITEMS / 2 && sent - RANDOM_ITEMS / 2 < 40) begin
                // let the block drain completely after bursts that end just past the halfway mark
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (board.pending.size() != 0);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0)
                    pause_sender(gap);
            end
        end

        i_in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
